[src/dtoi_pkg.sv]
// Shared types, character codes and helpers for the decimal text to int64 checker.
// No dependencies; imported by the top level and its bound checker.
package dtoi_pkg;

  // Character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Width of the running product magnitude*10 + digit
  localparam int unsigned PROD_W = 68;
  localparam int unsigned MAG_W  = 64;

  // Parse phase
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_REJECT = 3'd4
  } phase_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[CHAR_ZERO:CHAR_NINE]});
  endfunction

endpackage

[src/decimal_text_to_int64_checker.sv]
// Top level: parses a NUL-terminated decimal text into a signed 64-bit value.
// Depends on dtoi_pkg.
// The result of a text appears on the master side in the cycle after its NUL
//   byte is accepted. Throughput: one byte per cycle unless a result stalls;
//   the x10, add and range compare on the 64-bit magnitude is the longest path.
// Reset: rst (synchronous, active high) returns the parser to the leading
//   whitespace phase and empties the output register.
module decimal_text_to_int64_checker
  import dtoi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] number
  output logic        m_axis_tuser    // [0] accepted
);

  // Parser state
  phase_t             phase, phase_next;
  logic               negative, negative_next;
  logic [MAG_W-1:0]   magnitude, magnitude_next;

  // Output register
  logic               out_valid;
  logic               out_accepted;
  logic [MAG_W-1:0]   out_number;

  logic               in_fire;
  logic               is_term;
  logic [3:0]         digit;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  limit;
  logic               fits;
  logic               res_ok;
  logic [MAG_W-1:0]   res_value;

  // Output stage frees itself when its item is taken
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_term       = (s_axis_tdata == CHAR_NUL);

  // magnitude*10 + digit, checked against 2^63-1 (or 2^63 when negative)
  assign digit = 4'((s_axis_tdata - CHAR_ZERO) & 8'h0F);
  assign prod  = ({{(PROD_W-MAG_W){1'b0}}, magnitude} << 3)
               + ({{(PROD_W-MAG_W){1'b0}}, magnitude} << 1)
               + {{(PROD_W-4){1'b0}}, digit};
  assign limit = {{(PROD_W-MAG_W+1){1'b0}}, {(MAG_W-1){1'b1}}}
               + {{(PROD_W-1){1'b0}}, negative};
  assign fits  = (prod <= limit);

  // Next-state logic
  always_comb begin
    phase_next     = phase;
    negative_next  = negative;
    magnitude_next = magnitude;
    if (is_term) begin
      phase_next     = PH_LEAD;
      negative_next  = 1'b0;
      magnitude_next = '0;
    end else begin
      case (phase)
        PH_LEAD: begin
          if (is_space(s_axis_tdata)) begin
            phase_next = PH_LEAD;
          end else if (s_axis_tdata == CHAR_PLUS || s_axis_tdata == CHAR_MINUS) begin
            negative_next = (s_axis_tdata == CHAR_MINUS);
            phase_next    = PH_SIGN;
          end else if (is_digit(s_axis_tdata) && fits) begin
            magnitude_next = prod[MAG_W-1:0];
            phase_next     = PH_DIGITS;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit(s_axis_tdata)) begin
            if (fits) begin
              magnitude_next = prod[MAG_W-1:0];
              phase_next     = PH_DIGITS;
            end else begin
              phase_next = PH_REJECT;
            end
          end else if (phase == PH_DIGITS && is_space(s_axis_tdata)) begin
            phase_next = PH_TRAIL;
          end else begin
            phase_next = PH_REJECT;
          end
        end
        PH_TRAIL: begin
          if (!is_space(s_axis_tdata)) begin
            phase_next = PH_REJECT;
          end
        end
        default: begin
          phase_next = PH_REJECT;
        end
      endcase
    end
  end

  // Result of a text at its terminator
  always_comb begin
    res_ok    = (phase == PH_DIGITS) || (phase == PH_TRAIL);
    res_value = '0;
    if (res_ok) begin
      res_value = negative ? (~magnitude + 64'd1) : magnitude;
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      negative  <= 1'b0;
      magnitude <= '0;
    end else if (in_fire) begin
      phase     <= phase_next;
      negative  <= negative_next;
      magnitude <= magnitude_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && is_term) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_term) begin
      out_accepted <= res_ok;
      out_number   <= res_value;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_number;
  assign m_axis_tuser  = out_accepted;

endmodule

[src/dtoi_checker.sv]
// Port-level assertions for decimal_text_to_int64_checker, attached by bind.
// Depends on dtoi_pkg.
module dtoi_checker
  import dtoi_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Every accepted terminator yields a result in the next cycle
  a_term_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata == CHAR_NUL) |=> m_axis_tvalid)
    else $error("terminator gave no result");

  // A rejected text reports zero
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == 64'd0))
    else $error("rejected text with nonzero number");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind decimal_text_to_int64_checker dtoi_checker u_dtoi_checker (.*);
